// ===== design/pfb_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the position frame builder.
// Used by every module of the block; depends on nothing else.
package pfb_pkg;

  localparam int FRAME_LEN   = 12;
  localparam int POS_W       = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] FRAME_MAGIC   = 8'hD5;
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam logic [7:0] FRAME_TYPE    = 8'h01;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [7:0] CRC_INIT      = 8'h00;
  localparam logic [3:0] KEY_RESET     = 4'd13;
  localparam logic [7:0] QUALITY_RESET = 8'd100;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUALITY = 2'd1;

  // Command codes carried on the input tuser.
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_TX_OK = 1'b1;

  // Byte positions within the frame.
  localparam logic [POS_W-1:0] POS_MAGIC     = 4'd0;
  localparam logic [POS_W-1:0] POS_VERSION   = 4'd1;
  localparam logic [POS_W-1:0] POS_KEY       = 4'd2;
  localparam logic [POS_W-1:0] POS_TYPE      = 4'd3;
  localparam logic [POS_W-1:0] POS_RADIAL_LO = 4'd4;
  localparam logic [POS_W-1:0] POS_RADIAL_HI = 4'd5;
  localparam logic [POS_W-1:0] POS_ANGLE_LO  = 4'd6;
  localparam logic [POS_W-1:0] POS_ANGLE_HI  = 4'd7;
  localparam logic [POS_W-1:0] POS_SEQ_LO    = 4'd8;
  localparam logic [POS_W-1:0] POS_SEQ_HI    = 4'd9;
  localparam logic [POS_W-1:0] POS_QUALITY   = 4'd10;
  localparam logic [POS_W-1:0] POS_CRC       = 4'd11;

  // Everything the back end needs to serialize one frame.
  typedef struct packed {
    logic [15:0]        radial_dist;
    logic signed [15:0] angle_tenths;
    logic [15:0]        seq;
    logic [3:0]         key;
    logic [7:0]         quality;
  } frame_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/pfb_front.sv =====
// Front end of the position frame builder: accepts input beats, holds the
// configuration registers and the sequence number, and pushes build jobs.
// Depends on pfb_pkg.
module pfb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,
  input  logic                               in_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pfb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  pfb_pkg::queue_status_t             q_status,
  output logic                               q_push,
  output pfb_pkg::frame_entry_t              q_entry
);

  logic [15:0] seq_r, seq_nxt;
  logic [3:0]  key_r, key_nxt;
  logic [7:0]  quality_r, quality_nxt;
  logic        accept;

  assign in_tready = !q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && (in_tuser == pfb_pkg::CMD_BUILD);

  assign q_entry.radial_dist  = in_tdata[15:0];
  assign q_entry.angle_tenths = in_tdata[31:16];
  assign q_entry.seq          = seq_r;
  assign q_entry.key          = key_r;
  assign q_entry.quality      = quality_r;

  always_comb begin
    seq_nxt     = seq_r;
    key_nxt     = key_r;
    quality_nxt = quality_r;
    if (accept && (in_tuser == pfb_pkg::CMD_TX_OK)) begin
      seq_nxt = seq_r + 16'd1;
    end
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == pfb_pkg::REG_KEY) begin
        key_nxt = cfg_data[3:0];
      end else if (cfg_index == pfb_pkg::REG_QUALITY) begin
        quality_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= 16'd0;
      key_r     <= pfb_pkg::KEY_RESET;
      quality_r <= pfb_pkg::QUALITY_RESET;
    end else begin
      seq_r     <= seq_nxt;
      key_r     <= key_nxt;
      quality_r <= quality_nxt;
    end
  end

endmodule

// ===== design/pfb_queue.sv =====
// Small FIFO of build jobs between the front and back ends.
// Depends on pfb_pkg for the entry and status types.
module pfb_queue #(
  parameter int QDEPTH = pfb_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pfb_pkg::frame_entry_t  push_entry,
  input  logic                   pop,
  output pfb_pkg::frame_entry_t  head,
  output pfb_pkg::queue_status_t status
);

  // QDEPTH must be at least 2.
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  pfb_pkg::frame_entry_t mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/pfb_back.sv =====
// Back end of the position frame builder: serializes the job at the queue head
// into twelve output beats and accumulates the CRC-8 on the way. Depends on pfb_pkg.
module pfb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfb_pkg::frame_entry_t        head,
  input  pfb_pkg::queue_status_t       q_status,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,
  output logic                         out_tlast
);

  logic [pfb_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic [7:0]                crc_r, crc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_byte_r, out_byte_nxt;
  logic [pfb_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      advance, emit, at_crc;
  logic [7:0]                cur_byte;

  assign advance = !out_valid_r || out_tready;
  assign emit    = advance && !q_status.empty;
  assign at_crc  = (idx_r == pfb_pkg::POS_CRC);
  assign q_pop   = emit && at_crc;

  always_comb begin
    case (idx_r)
      pfb_pkg::POS_MAGIC:     cur_byte = pfb_pkg::FRAME_MAGIC;
      pfb_pkg::POS_VERSION:   cur_byte = pfb_pkg::FRAME_VERSION;
      pfb_pkg::POS_KEY:       cur_byte = {4'd0, head.key};
      pfb_pkg::POS_TYPE:      cur_byte = pfb_pkg::FRAME_TYPE;
      pfb_pkg::POS_RADIAL_LO: cur_byte = head.radial_dist[7:0];
      pfb_pkg::POS_RADIAL_HI: cur_byte = head.radial_dist[15:8];
      pfb_pkg::POS_ANGLE_LO:  cur_byte = head.angle_tenths[7:0];
      pfb_pkg::POS_ANGLE_HI:  cur_byte = head.angle_tenths[15:8];
      pfb_pkg::POS_SEQ_LO:    cur_byte = head.seq[7:0];
      pfb_pkg::POS_SEQ_HI:    cur_byte = head.seq[15:8];
      pfb_pkg::POS_QUALITY:   cur_byte = head.quality;
      pfb_pkg::POS_CRC:       cur_byte = crc_r;
      default:                cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_pos_nxt   = idx_r;
      out_last_nxt  = at_crc;
      if (at_crc) begin
        idx_nxt = pfb_pkg::POS_MAGIC;
        crc_nxt = pfb_pkg::CRC_INIT;
      end else begin
        idx_nxt = idx_r + pfb_pkg::POS_W'(1);
        crc_nxt = pfb_pkg::crc8_update(crc_r, cur_byte);
      end
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= pfb_pkg::POS_MAGIC;
      crc_r       <= pfb_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_pos_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== design/position_frame_builder_crc8_core.sv =====
// Top level of the position frame builder with CRC-8 framing.
// Instantiates pfb_front, pfb_queue and pfb_back; depends on pfb_pkg.
//
// A build beat (tuser 0) turns into a 12-byte position frame sent as twelve
// output beats: magic 0xD5, version 0x01, key id, type 0x01, radial distance
// and angle little endian, the current sequence number little endian, the
// quality byte, and a CRC-8 (polynomial 0x07, initial value 0) over the first
// eleven bytes, with tlast on the CRC beat. A transmit-success beat (tuser 1)
// advances the 16-bit sequence number and gives no output. Input beats are
// taken one per cycle as long as the job queue (QDEPTH frames deep) has room;
// the back end sends one byte per cycle while tready is high, and frames
// follow one another with no gap. A build beat is first written into the job
// queue; the back end then loads the first byte of its frame into its output
// register. Configuration writes are accepted in every cycle and should be
// made while no frame is queued or in flight.
module position_frame_builder_crc8_core #(
  parameter int QDEPTH = pfb_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [15:0] radial_dist, [31:16] angle_tenths
  input  logic                            in_tuser,   // [0] cmd
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [7:0] frame_byte, [11:8] byte_position
  output logic                            out_tlast,  // last_byte
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pfb_pkg::queue_status_t q_status;
  pfb_pkg::frame_entry_t  q_entry;
  pfb_pkg::frame_entry_t  q_head;
  logic                   q_push;
  logic                   q_pop;

  // The front end stamps each build job with the sequence number and
  // configuration current at acceptance, so later transmit-success beats
  // never disturb a frame already queued.
  pfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  pfb_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // The back end reads the job at the queue head in place and releases it
  // when it loads the CRC byte into its output register.
  pfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // tlast marks exactly the CRC position.
  a_last_at_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[11:8] == pfb_pkg::POS_CRC)))
    else $error("tlast does not match the CRC byte position");

  // Within a frame the byte positions step by one.
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (!out_tvalid || (out_tdata[11:8] == 4'($past(out_tdata[11:8]) + 4'd1))))
    else $error("byte position skipped within a frame");

  // After the CRC beat the next frame starts at the magic byte.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (!out_tvalid || ((out_tdata[11:8] == pfb_pkg::POS_MAGIC)
                       && (out_tdata[7:0] == pfb_pkg::FRAME_MAGIC))))
    else $error("frame did not restart at the magic byte");

  // The job queue is never popped while it is empty.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("job queue popped while empty");

endmodule

// ===== tb/tb_position_frame_builder_crc8_core.sv =====
// Self-checking testbench for position_frame_builder_crc8_core: directed and random beats,
// with every frame byte predicted locally and compared as it arrives.
// Depends on pfb_pkg and the core RTL only.
module tb_position_frame_builder_crc8_core;

  // Frame layout and CRC constants are kept locally so the prediction does not lean on the
  // constants the RTL itself uses.
  localparam logic [7:0] HDR_MAGIC       = 8'hD5;
  localparam logic [7:0] HDR_VERSION     = 8'h01;
  localparam logic [7:0] HDR_TYPE        = 8'h01;
  localparam logic [7:0] CRC8_POLY       = 8'h07;
  localparam int         BYTES_PER_FRAME = 12;
  localparam int         MAX_WAIT        = 11;
  localparam int         SETTLE_CYCLES   = 16;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         RANDOM_PHASES   = 6;
  localparam int         ITEMS_PER_PHASE = 65;
  localparam int         DIRECTED_ROWS   = 14;

  // The index field has room for two registers that do not exist; writes there are dropped.
  localparam logic [pfb_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [pfb_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  // One expected output beat of a frame.
  typedef struct packed {
    logic [7:0] value;
    logic [3:0] pos;
    logic       last;
  } frame_beat_t;

  // One row of the directed table. Where pin_seq_en is set, the sequence number the frame
  // must carry is typed in directly instead of taken from the running sequence count.
  typedef struct packed {
    logic        cmd;
    logic [15:0] radial;
    logic [15:0] angle;
    logic        pin_seq_en;
    logic [15:0] pin_seq;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata   = '0;   // [15:0] radial_dist, [31:16] angle_tenths
  logic                            in_tuser   = 1'b0; // [0] cmd
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;         // [7:0] frame_byte, [11:8] byte_position
  logic                            out_tlast;         // last_byte
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [pfb_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [pfb_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  // Local copy of the block's registers and sequence counter, kept in step with every
  // accepted beat and every accepted register write.
  logic [3:0]  model_key     = 4'd13;
  logic [7:0]  model_quality = 8'd100;
  logic [15:0] model_seq     = 16'h0000;

  frame_beat_t expected_bytes[$];
  int          mismatch_count = 0;

  // Idling controls. A burst flag removes the random wait on its side; hold_cycles asks the
  // result side for one long stall.
  bit src_burst   = 1'b0;
  bit sink_burst  = 1'b0;
  int hold_cycles = 0;

  // The directed table: frames right after reset, the field extremes, transmit success with
  // a busy payload that must be ignored, and builds back to back that must not move the
  // sequence number.
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{pfb_pkg::CMD_BUILD, 16'h0000, 16'h0000, 1'b1, 16'h0000},  // reset state, zero payload
    '{pfb_pkg::CMD_BUILD, 16'hFFFF, 16'h7FFF, 1'b1, 16'h0000},  // largest radial and angle
    '{pfb_pkg::CMD_BUILD, 16'h0000, 16'h8000, 1'b1, 16'h0000},  // most negative angle
    '{pfb_pkg::CMD_BUILD, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},  // angle of minus one
    '{pfb_pkg::CMD_TX_OK, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},  // payload ignored, seq to 1
    '{pfb_pkg::CMD_BUILD, 16'h8000, 16'h0001, 1'b1, 16'h0001},
    '{pfb_pkg::CMD_TX_OK, 16'h1234, 16'h5678, 1'b0, 16'h0000},
    '{pfb_pkg::CMD_TX_OK, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{pfb_pkg::CMD_BUILD, 16'h00FF, 16'hFF00, 1'b1, 16'h0003},
    '{pfb_pkg::CMD_BUILD, 16'hFF00, 16'h00FF, 1'b1, 16'h0003},  // building leaves seq alone
    '{pfb_pkg::CMD_BUILD, 16'hA5A5, 16'h5A5A, 1'b1, 16'h0003},
    '{pfb_pkg::CMD_TX_OK, 16'hAAAA, 16'h5555, 1'b0, 16'h0000},
    '{pfb_pkg::CMD_BUILD, 16'h5555, 16'hAAAA, 1'b1, 16'h0004},
    '{pfb_pkg::CMD_BUILD, 16'h0001, 16'hFFFE, 1'b1, 16'h0004}
  };

  position_frame_builder_crc8_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, many times the slowest legal run including the long receiver
  // hold.
  initial begin
    #2_000_000;
    $display("position_frame_builder_crc8_core regression: fail");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatch_count++;
    $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
  endtask

  // CRC-8 of the eleven frame bytes held in body, byte 0 in the low bits. The shift
  // register is clocked one message bit at a time, most significant bit of each byte first.
  function automatic logic [7:0] crc8_of_body(input logic [87:0] body);
    logic [7:0] crc;
    logic       feedback;
    crc = 8'h00;
    for (int i = 0; i < BYTES_PER_FRAME - 1; i++) begin
      for (int b = 7; b >= 0; b--) begin
        feedback = crc[7] ^ body[8*i + b];
        crc      = {crc[6:0], 1'b0} ^ (feedback ? CRC8_POLY : 8'h00);
      end
    end
    return crc;
  endfunction

  // Lays out one position frame from the current registers and the given sequence number
  // and queues its twelve bytes in transmission order.
  task automatic queue_frame(input logic [15:0] radial, input logic [15:0] angle,
                             input logic [15:0] seq);
    logic [95:0] frame;
    frame_beat_t beat;
    frame[87:0]  = {model_quality, seq, angle, radial, HDR_TYPE, 4'h0, model_key,
                    HDR_VERSION, HDR_MAGIC};
    frame[95:88] = crc8_of_body(frame[87:0]);
    for (int i = 0; i < BYTES_PER_FRAME; i++) begin
      beat.value = frame[8*i +: 8];
      beat.pos   = 4'(i);
      beat.last  = (4'(i) == pfb_pkg::POS_CRC);
      expected_bytes.push_back(beat);
    end
  endtask

  // Offers one input beat after a random gap and, once it is taken, advances the local
  // copy of the block: transmit success bumps the sequence, a build queues a frame.
  task automatic send_item(input logic cmd, input logic [15:0] radial,
                           input logic [15:0] angle, input logic pin_seq_en,
                           input logic [15:0] pin_seq);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {angle, radial};
    do @(posedge clk); while (in_tready !== 1'b1);
    if (cmd == pfb_pkg::CMD_TX_OK) begin
      model_seq = model_seq + 16'd1;
    end else begin
      queue_frame(radial, angle, pin_seq_en ? pin_seq : model_seq);
    end
  endtask

  // Register write; the valid drops for one cycle afterward so that two writes in a row
  // never assign cfg_valid twice in one time step.
  task automatic write_reg(input logic [pfb_pkg::CFG_INDEX_W-1:0] index,
                           input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (index)
      pfb_pkg::REG_KEY: begin
        model_key = value[3:0];
      end
      pfb_pkg::REG_QUALITY: begin
        model_quality = value;
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Stops offering beats, waits for every predicted byte, then lets the block settle before
  // the next register write.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_beat(input logic [7:0] value, input logic [3:0] pos,
                            input logic last);
    frame_beat_t want;
    if (expected_bytes.size() == 0) begin
      flag_mismatch("output beat with nothing expected", 16'h0000, {3'b0, value, pos, last});
    end else begin
      want = expected_bytes.pop_front();
      if (value !== want.value) flag_mismatch("frame_byte", 16'(want.value), 16'(value));
      if (pos !== want.pos) flag_mismatch("byte_position", 16'(want.pos), 16'(pos));
      if (last !== want.last) flag_mismatch("last_byte", 16'(want.last), 16'(last));
    end
  endtask

  // Result side. Each beat gets its own random stall, unless a burst is running; a hold
  // request from the stimulus adds one long stretch with tready low so the job queue fills
  // and the input side backs up.
  initial begin
    int unsigned stall;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold_cycles != 0) begin
        stall       = stall + hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_beat(out_tdata[7:0], out_tdata[11:8], out_tlast);
    end
  end

  // Stimulus: reset, the directed table, a short build and transmit-success run, then
  // random phases, each opened by register writes while the block is idle.
  initial begin
    logic        cmd;
    logic [15:0] radial;
    logic [15:0] angle;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].cmd, directed_rows[r].radial, directed_rows[r].angle,
                directed_rows[r].pin_seq_en, directed_rows[r].pin_seq);
    end

    // A build, a transmit success and a build, predicted from the running sequence count.
    send_item(pfb_pkg::CMD_BUILD, 16'h1357, 16'h9BDF, 1'b0, 16'h0000);
    send_item(pfb_pkg::CMD_TX_OK, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    send_item(pfb_pkg::CMD_BUILD, 16'hECA8, 16'h6420, 1'b0, 16'h0000);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          // Both registers at their lowest values.
          write_reg(pfb_pkg::REG_KEY, 8'h00);
          write_reg(pfb_pkg::REG_QUALITY, 8'h00);
        end
        1: begin
          // Highest values; the key write carries bits above its width that must drop,
          // and a write to a nonexistent register must change nothing.
          write_reg(pfb_pkg::REG_KEY, 8'hFF);
          write_reg(pfb_pkg::REG_QUALITY, 8'hFF);
          write_reg(REG_SPARE_A, 8'h5A);
        end
        2: begin
          write_reg(REG_SPARE_B, 8'hFF);
          write_reg(pfb_pkg::REG_KEY, 8'($urandom));
          write_reg(pfb_pkg::REG_QUALITY, 8'($urandom));
          hold_cycles = HOLD_CYCLES;
        end
        default: begin
          write_reg(pfb_pkg::REG_KEY, 8'($urandom));
          write_reg(pfb_pkg::REG_QUALITY, 8'($urandom));
        end
      endcase

      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        // Idling style changes every sixteen beats so that long gapless stretches and
        // heavily gapped ones both occur on each side.
        if (item % 16 == 0) begin
          src_burst  = ($urandom_range(0, 3) == 0);
          sink_burst = ($urandom_range(0, 3) == 0);
        end
        // While the receiver holds off, the sender keeps pushing without gaps.
        if (phase == 2 && item < 40) src_burst = 1'b1;

        cmd = ($urandom_range(0, 3) == 0) ? pfb_pkg::CMD_TX_OK : pfb_pkg::CMD_BUILD;
        case ($urandom_range(0, 7))
          0:       radial = 16'h0000;
          1:       radial = 16'hFFFF;
          default: radial = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       angle = 16'h8000;
          1:       angle = 16'h7FFF;
          2:       angle = 16'hFFFF;
          default: angle = 16'($urandom);
        endcase
        send_item(cmd, radial, angle, 1'b0, 16'h0000);
      end
    end

    src_burst  = 1'b0;
    sink_burst = 1'b0;
    wait_idle();

    if (mismatch_count == 0) begin
      $display("position_frame_builder_crc8_core regression: pass");
    end else begin
      $display("position_frame_builder_crc8_core regression: fail");
    end
    $finish;
  end

endmodule
